// ===== src/ttc_emergency_brake_decision_defines.svh =====
// ---------------------------------------------------------------------------
// TTC emergency brake decision: assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef TTC_EMERGENCY_BRAKE_DECISION_DEFINES_SVH
`define TTC_EMERGENCY_BRAKE_DECISION_DEFINES_SVH
`ifndef SYNTHESIS
`define TTC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TTC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TTC_ASSERT_IMP(label, clk, rst, ante, cons)
`define TTC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/ttc_pkg.sv =====
// ---------------------------------------------------------------------------
// TTC package
// Shared constants and types for the TTC emergency brake decision block.
// ---------------------------------------------------------------------------
`default_nettype none
package ttc_pkg;
  localparam int unsigned CfgW = 15;
  localparam logic [1:0] REG_ALARM = 2'd0;
  localparam logic [1:0] REG_BRAKE = 2'd1;
  localparam logic [1:0] REG_VMAX  = 2'd2;
  localparam logic [1:0] REG_VMIN  = 2'd3;
  localparam logic [CfgW-1:0] ALARM_RST = 15'd512;
  localparam logic [CfgW-1:0] BRAKE_RST = 15'd256;
  localparam logic [CfgW-1:0] VMAX_RST  = 15'd3840;
  localparam logic [CfgW-1:0] VMIN_RST  = 15'd640;
  localparam logic signed [15:0] TTC_MAX = 16'sd32767;
  localparam logic signed [15:0] TTC_MIN = -16'sd32768;
  localparam logic signed [15:0] TTC_NO_HIT = 16'sd25344;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL1 = 9'b000000010,
    ST_MUL2 = 9'b000000100,
    ST_MUL3 = 9'b000001000,
    ST_SQRT = 9'b000010000,
    ST_PREP = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_DEC  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

// ===== src/ttc_emergency_brake_decision.sv =====
// ---------------------------------------------------------------------------
// TTC emergency brake decision
// Time to collision from distance, speed and acceleration, with alarm,
// latched braking, seatbelt and door control.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (valid/ready): distance, speed, accel, aeb_on. One
//    transaction is taken only when the block is idle and its output
//    register is empty.
//  - Output channel (valid/ready): ttc, alarm, brake, belt_lock, door_lock,
//    one transaction per input transaction.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    index 0..3 = alarm, brake thresholds, max, min speed. Others ignored.
// Sequence: the non-negative acceleration path runs setup, divider, saturate
//  and decide from input to out_valid; the negative path runs multiply,
//  square root, prep, divider, saturate and decide. A new transaction is
//  taken only once the previous result has left the output register.
//  Timing is set by the shared restoring divider (one quotient bit a cycle)
//  and the bit-pair square root loop; one 32x32 multiplier is reused for
//  the two variable products of the discriminant.
// Reset: thresholds return to their defaults, braking and belt clear,
//  doors locked.
// Stall: the result holds in the output register until taken; no new
//  input transaction is taken meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none
`include "ttc_emergency_brake_decision_defines.svh"
module ttc_emergency_brake_decision #(
  parameter int unsigned CFG_W = ttc_pkg::CfgW
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [15:0]         distance,
  input  wire logic signed [15:0]  speed,
  input  wire logic signed [15:0]  accel,
  input  wire logic                aeb_on,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [15:0]       ttc,
  output logic                     alarm,
  output logic                     brake,
  output logic                     belt_lock,
  output logic                     door_lock,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);
  import ttc_pkg::*;

  state_t state;
  logic [CFG_W-1:0] thr_alarm, thr_brake, vmax, vmin;
  logic braking, belt_locked, doors_locked;

  // latched item
  logic [15:0] d_r;
  logic signed [15:0] s_r, a_r;
  logic on_r;

  // shared 32x32 multiplier, operands in registers
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  assign prod = mul_a * mul_b;

  // discriminant magnitude pieces (bs^2 and |42467328*A*D|)
  logic [63:0] bs2, acd;
  logic [63:0] rad;   // remaining radicand
  logic [63:0] root;
  logic [63:0] sbit;

  // divider: |num| / |den|, 40 bit dividend
  logic [39:0] dvd;
  logic [21:0] dvs;
  logic [22:0] rem;
  logic        q_neg;
  logic [5:0]  cnt;
  logic        force_max, force_nohit;
  logic signed [15:0] ttc_r;

  logic [22:0] rem_sh;
  assign rem_sh = {rem[21:0], dvd[39]};

  logic [63:0] sq_t;
  assign sq_t = root + sbit;

  // numerator for quadratic path: r - 5120*S (signed, fits 41 bits)
  logic signed [41:0] qnum;
  assign qnum = $signed({2'b00, root[39:0]}) - 42'(s_r) * 42'sd5120;

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_alarm <= CFG_W'(ALARM_RST);
      thr_brake <= CFG_W'(BRAKE_RST);
      vmax <= CFG_W'(VMAX_RST);
      vmin <= CFG_W'(VMIN_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALARM: thr_alarm <= cfg_data;
        REG_BRAKE: thr_brake <= cfg_data;
        REG_VMAX:  vmax <= cfg_data;
        REG_VMIN:  vmin <= cfg_data;
        default: ;
      endcase
    end
  end

  // result of divide, with saturation and special cases
  logic signed [15:0] div_ttc;
  always_comb begin
    if (force_max) div_ttc = TTC_MAX;
    else if (force_nohit) div_ttc = TTC_NO_HIT;
    else if (q_neg) div_ttc = (dvd > 40'd32768) ? TTC_MIN : -$signed(16'(dvd));
    else div_ttc = (dvd > 40'd32767) ? TTC_MAX : $signed(16'(dvd));
  end

  logic signed [17:0] t18;
  logic alarm_hit, brake_hit, belt_hit;
  always_comb begin
    t18 = 18'(ttc_r);
    alarm_hit = on_r && (ttc_r > 16'sd0) && (t18 < $signed({3'b0, thr_alarm}));
    brake_hit = alarm_hit && (t18 < $signed({3'b0, thr_brake})) && !braking
                && ($signed(18'(s_r)) < $signed({3'b0, vmax}))
                && ($signed(18'(s_r)) > $signed({3'b0, vmin}));
    belt_hit  = brake_hit && ((t18 <<< 1) < $signed({3'b0, thr_brake}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      braking <= 1'b0;
      belt_locked <= 1'b0;
      doors_locked <= 1'b1;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            d_r <= distance; s_r <= speed; a_r <= accel; on_r <= aeb_on;
            force_max <= 1'b0; force_nohit <= 1'b0;
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (a_r >= 0) begin
            // dividend 1152*D, divisor 5*|S|
            dvd <= 40'(d_r) * 40'd1152;
            dvs <= 22'(s_r[15] ? -32'(s_r) : 32'(s_r)) * 22'd5;
            q_neg <= s_r[15];
            force_max <= (s_r == 16'sd0);
            rem <= '0; cnt <= 6'd40;
            state <= ST_DIV;
          end else begin
            mul_a <= 32'(s_r[15] ? -32'(s_r) : 32'(s_r)) * 32'd5120;
            mul_b <= 32'(s_r[15] ? -32'(s_r) : 32'(s_r)) * 32'd5120;
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          bs2 <= prod;
          mul_a <= 32'(-32'(a_r));
          mul_b <= 32'(d_r);
          state <= ST_MUL3;
        end
        ST_MUL3: begin
          // |A|*D < 2^31, times 42467328 = 81 * 2^19
          acd <= (prod * 64'd81) << 19;
          state <= ST_SQRT;
          root <= '0;
          sbit <= 64'd1 << 62;
          rad <= '0;
          cnt <= 6'd0;
        end
        ST_SQRT: begin
          if (cnt == 6'd0) begin
            cnt <= 6'd1;
            if (acd > bs2) begin
              force_nohit <= 1'b1;
              rad <= '0;
            end else rad <= bs2 - acd;
          end else if (sbit == 64'd0) begin
            state <= ST_PREP;
          end else begin
            if (rad >= sq_t) begin
              rad <= rad - sq_t;
              root <= (root >> 1) + sbit;
            end else root <= root >> 1;
            sbit <= sbit >> 2;
          end
        end
        ST_PREP: begin
          // (r - bs) / (18*A); A<0 so sign flips
          dvd <= qnum[41] ? 40'(-qnum) : 40'(qnum);
          dvs <= 22'(-32'(a_r)) * 22'd18;
          q_neg <= !qnum[41] && (qnum != 0);
          rem <= '0; cnt <= 6'd40;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == 6'd0) begin
            state <= ST_DEC;
          end else begin
            cnt <= cnt - 6'd1;
            if (rem_sh >= {1'b0, dvs}) begin
              rem <= rem_sh - {1'b0, dvs};
              dvd <= {dvd[38:0], 1'b1};
            end else begin
              rem <= rem_sh;
              dvd <= {dvd[38:0], 1'b0};
            end
          end
        end
        ST_DEC: begin
          ttc_r <= div_ttc;
          state <= ST_OUT;
        end
        ST_OUT: begin
          ttc <= ttc_r;
          alarm <= alarm_hit;
          if (!alarm_hit) braking <= 1'b0;
          else if (brake_hit) braking <= 1'b1;
          brake <= alarm_hit && (braking || brake_hit);
          belt_lock <= belt_locked || belt_hit;
          door_lock <= doors_locked && !belt_hit;
          if (belt_hit) begin
            belt_locked <= 1'b1;
            doors_locked <= 1'b0;
          end
          out_valid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `TTC_ASSERT_IMP(a_no_accept_busy, clk, rst, state != ST_IDLE, !in_ready)
  `TTC_ASSERT_NXT(a_out_after_dec, clk, rst, state == ST_OUT, out_valid)
  `TTC_ASSERT_IMP(a_belt_doors, clk, rst, belt_locked, !doors_locked)
  `TTC_ASSERT_IMP(a_brake_alarm, clk, rst, out_valid && brake, alarm)
endmodule
`default_nettype wire

// ===== verif/ttc_emergency_brake_decision_tb.sv =====
// ---------------------------------------------------------------------------
// TTC emergency brake decision testbench
// Drives distance/speed/accel transactions through the block under several
// register settings and idle patterns, predicts each result locally and
// checks every output transaction field by field, in order.
// ---------------------------------------------------------------------------
module ttc_emergency_brake_decision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttc_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 200;

  // One expected output transaction
  typedef struct packed {
    logic signed [15:0] ttc;
    logic               alarm;
    logic               brake;
    logic               belt_lock;
    logic               door_lock;
  } decision_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [15:0]             distance = '0;
  logic signed [15:0]      speed = '0;
  logic signed [15:0]      accel = '0;
  logic                    aeb_on = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [15:0]      ttc;
  logic                    alarm;
  logic                    brake;
  logic                    belt_lock;
  logic                    door_lock;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index = REG_ALARM;
  logic [CfgW-1:0]         cfg_data = '0;

  // Local copy of the block's registers and latched state
  logic [CfgW-1:0] alarm_thr;
  logic [CfgW-1:0] brake_thr;
  logic [CfgW-1:0] vmax;
  logic [CfgW-1:0] vmin;
  logic            brake_latched;
  logic            belt_held;
  logic            doors_held;

  decision_t expected_q[$];
  int        mismatches = 0;
  int        send_gap_pct = 0;  // chance in 100 that the sender idles a cycle
  int        recv_stall_pct = 0; // chance in 100 that the receiver stalls

  ttc_emergency_brake_decision u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .distance  (distance),
    .speed     (speed),
    .accel     (accel),
    .aeb_on    (aeb_on),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ttc       (ttc),
    .alarm     (alarm),
    .brake     (brake),
    .belt_lock (belt_lock),
    .door_lock (door_lock),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // Floor square root, bit-pair method
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > x) probe >>= 2;
    while (probe != 0) begin
      if (x >= root + probe) begin
        x    = x - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Time to collision in 1/256 s. Gap model c - b*t - (a/2)*t^2 scaled so
  // that everything stays integer until the last divide.
  function automatic logic signed [15:0] collision_time(logic [15:0] d_in,
                                                        logic signed [15:0] s_in,
                                                        logic signed [15:0] a_in);
    longint d;
    longint s;
    longint a;
    longint bs;
    longint disc;
    longint q;
    d = d_in;
    s = s_in;
    a = a_in;
    if (a >= 0) begin
      if (s == 0) return TTC_MAX;
      q = (d * 1152) / (5 * s);
    end else begin
      bs   = 5120 * s;
      disc = bs * bs + 42467328 * a * d;
      if (disc < 0) return TTC_NO_HIT;  // never closes the gap: 99 s
      q = (longint'(floor_sqrt(disc)) - bs) / (18 * a);
    end
    if (q > 32767) return TTC_MAX;
    if (q < -32768) return TTC_MIN;
    return q[15:0];
  endfunction

  // Alarm and braking decision; updates the latched state
  function automatic decision_t brake_decision(logic [15:0] d, logic signed [15:0] s,
                                               logic signed [15:0] a, logic on);
    decision_t res;
    longint    t;
    res.ttc   = collision_time(d, s, a);
    res.alarm = 1'b0;
    t = res.ttc;
    if (on && t > 0 && t < longint'(alarm_thr)) begin
      res.alarm = 1'b1;
      if (t < longint'(brake_thr) && !brake_latched &&
          longint'(s) < longint'(vmax) && longint'(s) > longint'(vmin)) begin
        brake_latched = 1'b1;
        // below half the braking threshold: belt locks, doors open
        if (2 * t < longint'(brake_thr)) begin
          belt_held  = 1'b1;
          doors_held = 1'b0;
        end
      end
    end else begin
      brake_latched = 1'b0;
    end
    res.brake     = brake_latched;
    res.belt_lock = belt_held;
    res.door_lock = doors_held;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Receiver: random stalls, and the result check
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(string field, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    decision_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction, ttc", ttc, 0);
      end else begin
        want = expected_q.pop_front();
        if (ttc !== want.ttc) report_mismatch("ttc", ttc, want.ttc);
        if (alarm !== want.alarm) report_mismatch("alarm", alarm, want.alarm);
        if (brake !== want.brake) report_mismatch("brake", brake, want.brake);
        if (belt_lock !== want.belt_lock)
          report_mismatch("belt_lock", belt_lock, want.belt_lock);
        if (door_lock !== want.door_lock)
          report_mismatch("door_lock", door_lock, want.door_lock);
      end
    end
  end

  // Watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    int quiet;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------------

  // Sends one transaction; valid stays high across back-to-back items
  task automatic send_item(logic [15:0] d, logic signed [15:0] s,
                           logic signed [15:0] a, logic on);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    distance <= d;
    speed    <= s;
    accel    <= a;
    aeb_on   <= on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(brake_decision(d, s, a, on));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Register write, only with nothing in flight
  task automatic write_reg(logic [1:0] idx, logic [CfgW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ALARM: alarm_thr = value;
      REG_BRAKE: brake_thr = value;
      REG_VMAX:  vmax      = value;
      REG_VMIN:  vmin      = value;
      default:   ;
    endcase
  endtask

  task automatic write_all(logic [CfgW-1:0] a_thr, logic [CfgW-1:0] b_thr,
                           logic [CfgW-1:0] v_hi, logic [CfgW-1:0] v_lo);
    write_reg(REG_ALARM, a_thr);
    write_reg(REG_BRAKE, b_thr);
    write_reg(REG_VMAX, v_hi);
    write_reg(REG_VMIN, v_lo);
  endtask

  function automatic logic [CfgW-1:0] pick_reg(int lo_hint, int hi_hint);
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return CfgW'($urandom());
      default: return CfgW'($urandom_range(hi_hint, lo_hint));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Field extremes and the special cases, at reset register values
  task automatic test_directed();
    send_item(16'd0, 16'sd0, 16'sd0, 1'b1);          // zero speed: maximum time
    send_item(16'hFFFF, 16'sd1, 16'sd0, 1'b1);       // overflow saturates high
    send_item(16'hFFFF, -16'sd1, 16'sd100, 1'b1);    // overflow saturates low
    send_item(16'hFFFF, 16'sd32767, 16'sd32767, 1'b1);
    send_item(16'hFFFF, -16'sd32768, 16'sd0, 1'b1);
    send_item(16'd1000, 16'sd500, -16'sd1, 1'b1);    // quadratic, positive disc
    send_item(16'd65535, -16'sd32768, -16'sd32768, 1'b1); // negative disc: 99 s
    send_item(16'd10, 16'sd9, -16'sd5, 1'b1);        // zero disc: -b/a
    send_item(16'd0, 16'sd0, -16'sd1, 1'b1);         // zero disc, zero time
    send_item(16'd65535, 16'sd32767, -16'sd32768, 1'b1);
    send_item(16'd100, 16'sd1000, 16'sd0, 1'b0);     // function disabled
    send_item(16'd200, 16'sd1000, 16'sd0, 1'b1);     // alarm, braking, belt locks
    send_item(16'd100, 16'sd1000, 16'sd0, 1'b1);     // braking already latched
    send_item(16'd60000, 16'sd1000, 16'sd0, 1'b1);   // clears braking
    send_item(16'd100, 16'sd1000, 16'sd0, 1'b1);     // belt locks, doors open
    send_item(16'd100, 16'sd640, 16'sd0, 1'b1);      // speed on window edge
    send_item(16'd100, 16'sd3840, 16'sd0, 1'b1);
    send_item(16'd0, 16'sd1000, 16'sd0, 1'b1);       // zero time: no alarm
    send_item(16'd300, 16'sd1000, -16'sd300, 1'b1);
    wait_drained();
  endtask

  // Register extremes with a short burst each
  task automatic test_register_extremes();
    int k;
    write_all('0, '0, '0, '0);
    for (k = 0; k < 6; k++)
      send_item(16'($urandom_range(400)), 16'($urandom_range(4000)), 16'sd0, 1'b1);
    write_all('1, '1, '1, '0);
    for (k = 0; k < 6; k++)
      send_item(16'($urandom_range(2000)), 16'($urandom_range(4000, 1)),
                -$signed(16'($urandom_range(50))), 1'b1);
  endtask

  // Random traffic, mostly near-threat scenarios so the latches move
  task automatic test_random(int n_items);
    int k;
    logic [15:0]        d;
    logic signed [15:0] s;
    logic signed [15:0] a;
    logic               on;
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 65) begin
        d  = 16'($urandom_range(1500));
        s  = 16'($urandom_range(4500, 300));
        a  = ($urandom_range(1)) ? $signed(16'($urandom_range(400))) :
                                   -$signed(16'($urandom_range(600)));
        on = ($urandom_range(9) != 0);
      end else begin
        d  = 16'($urandom());
        s  = 16'($urandom());
        a  = 16'($urandom());
        on = 1'($urandom_range(1));
      end
      send_item(d, s, a, on);
    end
  endtask

  // Idle-pattern phases, each with fresh register settings
  task automatic test_idle_phases();
    int mode;
    int rep;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 46; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 46; end
        default: begin send_gap_pct = 8; recv_stall_pct = 8; end
      endcase
      for (rep = 0; rep < 4; rep++) begin
        if (rep == 0)
          write_all(ALARM_RST, BRAKE_RST, VMAX_RST, VMIN_RST);
        else
          write_all(pick_reg(100, 2000), pick_reg(50, 1000),
                    pick_reg(2000, 6000), pick_reg(0, 1500));
        test_random(88);
      end
    end
    send_gap_pct   = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    alarm_thr     = ALARM_RST;
    brake_thr     = BRAKE_RST;
    vmax          = VMAX_RST;
    vmin          = VMIN_RST;
    brake_latched = 1'b0;
    belt_held     = 1'b0;
    doors_held    = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_register_extremes();
    test_idle_phases();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
